// ----- rtl/rhcb_pkg.sv -----
// Shared types and constants for the ROM header checksum builder.
`default_nettype none

package rhcb_pkg;

    localparam int unsigned MAX_IMAGE_BYTES = 1048576;
    localparam int unsigned COUNT_W = 21;
    localparam int unsigned NUM_SLOTS = 3;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_IMAGE_BYTES);
    localparam logic [COUNT_W-1:0] UPPER_BASE = 21'h08000;
    localparam logic [COUNT_W-1:0] SIZE_MIN = 21'h02000;

    localparam logic [14:0] SLOT_LOC [NUM_SLOTS] = '{15'h1FF0, 15'h3FF0, 15'h7FF0};
    localparam logic [COUNT_W-1:0] SLOT_LEN = 21'd16;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_BIG   = 2'd1,
        STATUS_NOT_BLANK = 2'd2
    } status_t;

    typedef enum logic {
        REG_PRODUCT  = 1'b0,
        REG_REVISION = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [COUNT_W-1:0]          count;
        logic [15:0]                 upper;
        logic [NUM_SLOTS-1:0][15:0]  prefix;
        logic [NUM_SLOTS-1:0][7:0]   first;
        logic [NUM_SLOTS-1:0]        blank;
        logic                        oversize;
    } acc_t;

    typedef struct packed {
        status_t             status;
        logic [14:0]         loc;
        logic [COUNT_W-1:0]  size;
        logic [15:0]         sum;
        logic [3:0]          code;
    } run_t;

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] mid;
        logic [3:0] hi;
    } bcd_t;

endpackage

`default_nettype wire

// ----- rtl/rhcb_bcd.sv -----
// Pipelined binary to packed BCD conversion of the product number.
`default_nettype none

module rhcb_bcd
    import rhcb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic [17:0] product,
    output bcd_t             bcd
);

    localparam logic [36:0] RECIP_100_WIDE = 37'd335545;
    localparam logic [24:0] RECIP_100_NARROW = 25'd5243;
    localparam logic [14:0] RECIP_10 = 15'd205;

    logic [17:0] n_a_reg;
    logic [11:0] q1_a_reg;
    logic [11:0] q1_b_reg;
    logic [6:0]  r1_b_reg;
    logic [4:0]  q2_b_reg;
    logic [6:0]  r1_c_reg;
    logic [6:0]  r2_c_reg;
    logic [4:0]  q2_c_reg;
    bcd_t        bcd_reg;

    logic [36:0] prod_a;
    logic [24:0] prod_b;
    logic [17:0] hundreds_b;
    logic [11:0] hundreds_c;
    logic [14:0] prod_t1;
    logic [14:0] prod_t2;
    logic [3:0]  tens1;
    logic [3:0]  tens2;
    logic [6:0]  ones1;
    logic [6:0]  ones2;
    bcd_t        bcd_next;

    always_comb begin
        prod_a     = 37'(product) * RECIP_100_WIDE;
        prod_b     = 25'(q1_a_reg) * RECIP_100_NARROW;
        hundreds_b = 18'(q1_a_reg) * 18'd100;
        hundreds_c = 12'(q2_b_reg) * 12'd100;
        prod_t1    = 15'(r1_c_reg) * RECIP_10;
        prod_t2    = 15'(r2_c_reg) * RECIP_10;
        tens1      = prod_t1[14:11];
        tens2      = prod_t2[14:11];
        ones1      = r1_c_reg - 7'(tens1) * 7'd10;
        ones2      = r2_c_reg - 7'(tens2) * 7'd10;
        bcd_next.lo  = {tens1, ones1[3:0]};
        bcd_next.mid = {tens2, ones2[3:0]};
        bcd_next.hi  = q2_c_reg[3:0];
    end

    always_ff @(posedge aclk) begin
        n_a_reg  <= product;
        q1_a_reg <= prod_a[36:25];
        q1_b_reg <= q1_a_reg;
        r1_b_reg <= 7'(n_a_reg - hundreds_b);
        q2_b_reg <= prod_b[23:19];
        r1_c_reg <= r1_b_reg;
        r2_c_reg <= 7'(q1_b_reg - hundreds_c);
        q2_c_reg <= q2_b_reg;
        bcd_reg  <= bcd_next;
    end

    assign bcd = bcd_reg;

endmodule

`default_nettype wire

// ----- rtl/rhcb_accum.sv -----
// Per-byte accumulation of count, upper-region sum, slot prefix sums, blank checks and oversize flag.
`default_nettype none

module rhcb_accum
    import rhcb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       snap_take,
    output logic            snap_valid,
    output acc_t            snap
);

    acc_t acc_reg;
    acc_t acc_next;
    acc_t upd;
    acc_t clear_val;
    acc_t snap_reg;
    acc_t snap_next;
    logic snap_valid_reg;
    logic snap_valid_next;
    logic [COUNT_W-1:0] addr;
    logic [COUNT_W-1:0] loc;
    logic [7:0] first_eff;

    always_comb begin
        clear_val          = '0;
        clear_val.blank    = '1;

        addr      = acc_reg.count;
        upd       = acc_reg;
        loc       = '0;
        first_eff = '0;
        if (addr >= MAX_COUNT) begin
            upd.oversize = 1'b1;
        end else begin
            if (addr >= UPPER_BASE) begin
                upd.upper = acc_reg.upper + 16'(data_byte);
            end
            for (int s = 0; s < NUM_SLOTS; s++) begin
                loc = COUNT_W'(SLOT_LOC[s]);
                first_eff = (addr == loc) ? data_byte : acc_reg.first[s];
                if (addr < loc) begin
                    upd.prefix[s] = acc_reg.prefix[s] + 16'(data_byte);
                end else if (addr < loc + SLOT_LEN) begin
                    upd.first[s] = first_eff;
                    if ((data_byte != 8'h00 && data_byte != 8'hFF) ||
                        data_byte != first_eff) begin
                        upd.blank[s] = 1'b0;
                    end
                end
            end
        end
        if (addr <= MAX_COUNT) begin
            upd.count = addr + 1'b1;
        end

        acc_next        = acc_reg;
        snap_next       = snap_reg;
        snap_valid_next = snap_valid_reg;
        if (snap_take) begin
            snap_valid_next = 1'b0;
        end
        if (accept) begin
            if (last_byte) begin
                acc_next        = clear_val;
                snap_next       = upd;
                snap_valid_next = 1'b1;
            end else begin
                acc_next = upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg          <= clear_val;
            snap_valid_reg   <= 1'b0;
        end else begin
            acc_reg        <= acc_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        snap_reg <= snap_next;
    end

    assign snap       = snap_reg;
    assign snap_valid = snap_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/rhcb_finish.sv -----
// End-of-image evaluation: padded size, slot choice, blank check and checksum.
`default_nettype none

module rhcb_finish
    import rhcb_pkg::*;
(
    input  wire acc_t snap,
    output run_t      run
);

    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] padded_total;
    logic [COUNT_W-1:0] loc;
    logic [COUNT_W-1:0] base_hi;
    logic [3:0]         code;
    logic [1:0]         sel;
    logic               ok;
    logic [15:0]        pad_lo;
    logic [15:0]        pad_hi;
    logic [15:0]        term_lo;
    logic [15:0]        term_hi;
    logic [15:0]        sum;

    always_comb begin
        count = snap.count;
        priority if (count <= 21'h002000) begin
            padded_total = 21'h002000;
            code         = 4'hA;
        end else if (count <= 21'h004000) begin
            padded_total = 21'h004000;
            code         = 4'hB;
        end else if (count <= 21'h008000) begin
            padded_total = 21'h008000;
            code         = 4'hC;
        end else if (count <= 21'h010000) begin
            padded_total = 21'h010000;
            code         = 4'hE;
        end else if (count <= 21'h020000) begin
            padded_total = 21'h020000;
            code         = 4'hF;
        end else if (count <= 21'h040000) begin
            padded_total = 21'h040000;
            code         = 4'h0;
        end else if (count <= 21'h080000) begin
            padded_total = 21'h080000;
            code         = 4'h1;
        end else begin
            padded_total = 21'h100000;
            code         = 4'h2;
        end

        priority if (padded_total == SIZE_MIN) begin
            sel = 2'd0;
        end else if (padded_total == (SIZE_MIN << 1)) begin
            sel = 2'd1;
        end else begin
            sel = 2'd2;
        end
        loc = COUNT_W'(SLOT_LOC[sel]);

        ok = snap.blank[sel];
        if (count <= loc) begin
            ok = 1'b1;
        end else if (count < loc + SLOT_LEN) begin
            ok = ok && (snap.first[sel] == 8'hFF);
        end

        pad_lo = (count < loc) ? 16'(loc - count) : 16'h0000;
        base_hi = (count > UPPER_BASE) ? count : UPPER_BASE;
        pad_hi = (padded_total > base_hi) ? 16'(padded_total - base_hi) : 16'h0000;
        term_lo = (pad_lo << 8) - pad_lo;
        term_hi = (pad_hi << 8) - pad_hi;
        sum = snap.prefix[sel] + snap.upper + term_lo + term_hi;

        priority if (snap.oversize) begin
            run.status = STATUS_TOO_BIG;
            run.loc    = '0;
            run.size   = '0;
            run.sum    = '0;
            run.code   = code;
        end else if (!ok) begin
            run.status = STATUS_NOT_BLANK;
            run.loc    = loc[14:0];
            run.size   = padded_total;
            run.sum    = '0;
            run.code   = code;
        end else begin
            run.status = STATUS_OK;
            run.loc    = loc[14:0];
            run.size   = padded_total;
            run.sum    = sum;
            run.code   = code;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rhcb_emit.sv -----
// Result register and header byte sequencer for one finished image.
`default_nettype none

module rhcb_emit
    import rhcb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        snap_valid,
    input  wire run_t        run_in,
    output logic             snap_take,
    input  wire bcd_t        bcd,
    input  wire logic [3:0]  revision,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_header_byte,
    output logic [3:0]       m_byte_offset,
    output logic [14:0]      m_header_address,
    output logic [20:0]      m_padded_size,
    output logic [15:0]      m_checksum,
    output logic [1:0]       m_status,
    output logic             m_last_of_run
);

    localparam logic [7:0] SIG_TEXT [10] = '{
        8'h54, 8'h4D, 8'h52, 8'h20, 8'h53, 8'h45, 8'h47, 8'h41, 8'h20, 8'h20
    };

    run_t       run_reg;
    logic       run_valid_reg;
    logic       run_valid_next;
    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic       is_error;
    logic       out_last;
    logic       beat_done;

    always_comb begin
        is_error  = (run_reg.status != STATUS_OK);
        out_last  = is_error || (pos_reg == 4'd15);
        beat_done = run_valid_reg && m_ready;
        snap_take = snap_valid && (!run_valid_reg || (beat_done && out_last));

        run_valid_next = run_valid_reg;
        pos_next       = pos_reg;
        if (beat_done) begin
            pos_next = pos_reg + 1'b1;
            if (out_last) begin
                run_valid_next = 1'b0;
            end
        end
        if (snap_take) begin
            run_valid_next = 1'b1;
            pos_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end else begin
            run_valid_reg <= run_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_take) begin
            run_reg <= run_in;
        end
    end

    always_comb begin
        if (is_error) begin
            m_header_byte = 8'h00;
        end else begin
            unique case (pos_reg)
                4'd0, 4'd1, 4'd2, 4'd3, 4'd4,
                4'd5, 4'd6, 4'd7, 4'd8, 4'd9: m_header_byte = SIG_TEXT[pos_reg];
                4'd10: m_header_byte = run_reg.sum[7:0];
                4'd11: m_header_byte = run_reg.sum[15:8];
                4'd12: m_header_byte = bcd.lo;
                4'd13: m_header_byte = bcd.mid;
                4'd14: m_header_byte = {bcd.hi, revision};
                4'd15: m_header_byte = {4'h4, run_reg.code};
            endcase
        end
    end

    assign m_valid          = run_valid_reg;
    assign m_byte_offset    = is_error ? 4'd0 : pos_reg;
    assign m_header_address = run_reg.loc;
    assign m_padded_size    = run_reg.size;
    assign m_checksum       = run_reg.sum;
    assign m_status         = run_reg.status;
    assign m_last_of_run    = out_last;

endmodule

`default_nettype wire

// ----- rtl/rom_header_checksum_builder_unit.sv -----
// Top level of the ROM header checksum builder.
//
// The s_ channel takes the ROM image one byte per beat in address order;
// s_last_byte marks the final byte. One beat is accepted per cycle while
// s_ready is high: each byte updates the byte counter, the upper-region sum,
// the slot prefix sums, the blank checks and the oversize flag in the
// accumulator registers. A last beat moves the image totals into a holding
// register. When the result register is free in that cycle, s_ready stays
// high and the next image can follow with no gap; s_ready drops only while a
// finished image waits for the previous header to be sent. A good image
// yields 16 beats (header bytes 0 to 15), an oversize or non-blank slot image
// yields a single error beat; m_last_of_run flags the final beat. The m_
// channel sends one beat per cycle; when the receiver stalls, the current beat
// holds and input keeps streaming until the next last beat. Configuration is
// written through cfg_we/cfg_index/cfg_data; the user must do so only while
// the block is idle, as the block itself has no check for it. A synchronous
// low on aresetn clears the registers, the accumulators and the queued run.
`default_nettype none

module rom_header_checksum_builder_unit
    import rhcb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [17:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_header_byte,
    output logic [3:0]       m_byte_offset,
    output logic [14:0]      m_header_address,
    output logic [20:0]      m_padded_size,
    output logic [15:0]      m_checksum,
    output logic [1:0]       m_status,
    output logic             m_last_of_run
);

    logic [17:0] product_reg;
    logic [17:0] product_next;
    logic [3:0]  revision_reg;
    logic [3:0]  revision_next;
    logic        accept;
    logic        snap_valid;
    logic        snap_take;
    acc_t        snap;
    run_t        run;
    bcd_t        bcd;
    reg_index_t  cfg_sel;

    always_comb begin
        cfg_sel       = reg_index_t'(cfg_index);
        product_next  = product_reg;
        revision_next = revision_reg;
        if (cfg_we) begin
            unique case (cfg_sel)
                REG_PRODUCT:  product_next  = cfg_data;
                REG_REVISION: revision_next = cfg_data[3:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            product_reg  <= '0;
            revision_reg <= '0;
        end else begin
            product_reg  <= product_next;
            revision_reg <= revision_next;
        end
    end

    assign s_ready = !snap_valid || snap_take;
    assign accept  = s_valid && s_ready;

    rhcb_bcd u_bcd (
        .aclk    (aclk),
        .product (product_reg),
        .bcd     (bcd)
    );

    rhcb_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .data_byte  (s_data_byte),
        .last_byte  (s_last_byte),
        .snap_take  (snap_take),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    rhcb_finish u_finish (
        .snap (snap),
        .run  (run)
    );

    rhcb_emit u_emit (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .snap_valid       (snap_valid),
        .run_in           (run),
        .snap_take        (snap_take),
        .bcd              (bcd),
        .revision         (revision_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_header_byte    (m_header_byte),
        .m_byte_offset    (m_byte_offset),
        .m_header_address (m_header_address),
        .m_padded_size    (m_padded_size),
        .m_checksum       (m_checksum),
        .m_status         (m_status),
        .m_last_of_run    (m_last_of_run)
    );

endmodule

`default_nettype wire
